@@ hw/rtl/fsa_pkg.sv @@
// fsa_pkg: shared types, constants and register indexes of the fixed step accumulator
// depends on nothing; used by the interfaces, controller, datapath and top level
`default_nettype none

package fsa_pkg;

	localparam int ACC_W      = 25;
	localparam int PERIOD_W   = 20;
	localparam int FRAME_W    = 24;
	localparam int CATCH_W    = 4;
	localparam int IDX_W      = 3;
	localparam int DROP_W     = 24;
	localparam int FRAC_W     = 16;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam int MAX_STEPS_DEF = 8;

	localparam logic [PERIOD_W-1:0] DEF_PERIOD = 20'd16667;
	localparam logic [PERIOD_W-1:0] MIN_PERIOD = 20'd1000;
	localparam logic [PERIOD_W-1:0] MAX_PERIOD = 20'd1000000;
	localparam logic [FRAME_W-1:0]  DEF_FRAME  = 24'd250000;
	localparam logic [CATCH_W-1:0]  DEF_CATCH  = 4'd5;

	// quotient bits of the accumulator divide, then fraction bits
	localparam logic [CNT_W-1:0] DIV_LAST_CNT  = 5'(ACC_W - 1);
	localparam logic [CNT_W-1:0] FRAC_LAST_CNT = 5'(FRAC_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_PERIOD  = 2'd0,
		REG_MAX_CATCH_UP = 2'd1,
		REG_MAX_FRAME    = 2'd2
	} fsa_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SPLIT,
		ST_FRACTION,
		ST_EMIT
	} fsa_state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic split;
		logic emit_step;
		logic emit_final;
	} fsa_cmd_t;

	typedef struct packed {
		logic last_iter;
		logic more_steps;
		logic out_free;
	} fsa_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/fsa_frame_if.sv @@
// fsa_frame_if: valid/ready channel carrying one frame duration per transaction
// depends on fsa_pkg
`default_nettype none

interface fsa_frame_if;
	logic                                valid;
	logic                                ready;
	logic signed [fsa_pkg::FRAME_W-1:0]  frame_time_us;

	modport source (output valid, output frame_time_us, input ready);
	modport sink   (input valid, input frame_time_us, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fsa_step_if.sv @@
// fsa_step_if: valid/ready channel carrying one step or summary result per transaction
// depends on fsa_pkg
`default_nettype none

interface fsa_step_if;
	logic                          valid;
	logic                          ready;
	logic                          step_granted;
	logic [fsa_pkg::IDX_W-1:0]     step_index;
	logic [fsa_pkg::DROP_W-1:0]    dropped_steps;
	logic [fsa_pkg::FRAC_W-1:0]    blend_fraction;
	logic                          last;

	modport source (output valid, output step_granted, output step_index,
		output dropped_steps, output blend_fraction, output last, input ready);
	modport sink   (input valid, input step_granted, input step_index,
		input dropped_steps, input blend_fraction, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fsa_ctrl.sv @@
// fsa_ctrl: sequencing state machine for the fixed step accumulator
// depends on fsa_pkg; drives commands into fsa_dp and reads its status
`default_nettype none

module fsa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire fsa_pkg::fsa_sts_t sts,
	output fsa_pkg::fsa_cmd_t      cmd
);

	fsa_pkg::fsa_state_t state_q;
	fsa_pkg::fsa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsa_pkg::ST_IDLE: begin
				if (in_valid) state_d = fsa_pkg::ST_DIVIDE;
			end
			fsa_pkg::ST_DIVIDE: begin
				if (sts.last_iter) state_d = fsa_pkg::ST_SPLIT;
			end
			fsa_pkg::ST_SPLIT: begin
				state_d = fsa_pkg::ST_FRACTION;
			end
			fsa_pkg::ST_FRACTION: begin
				if (sts.last_iter) state_d = fsa_pkg::ST_EMIT;
			end
			fsa_pkg::ST_EMIT: begin
				if (sts.out_free && !sts.more_steps) state_d = fsa_pkg::ST_IDLE;
			end
			default: state_d = fsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			fsa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			fsa_pkg::ST_DIVIDE, fsa_pkg::ST_FRACTION: begin
				cmd.div_step = 1'b1;
			end
			fsa_pkg::ST_SPLIT: begin
				cmd.split = 1'b1;
			end
			fsa_pkg::ST_EMIT: begin
				cmd.emit_step  = sts.out_free && sts.more_steps;
				cmd.emit_final = sts.out_free && !sts.more_steps;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// results are only launched into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step || cmd.emit_final) |-> sts.out_free)
		else $error("result launched while output register busy");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.div_step, cmd.split, cmd.emit_step, cmd.emit_final}))
		else $error("more than one datapath command at once");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_final |=> in_ready)
		else $error("not back to idle after the summary result");

endmodule

`default_nettype wire

@@ hw/rtl/fsa_dp.sv @@
// fsa_dp: config registers, accumulator, shared restoring divider and output register
// depends on fsa_pkg; commanded by fsa_ctrl
`default_nettype none

module fsa_dp #(
	parameter int MAX_STEPS = fsa_pkg::MAX_STEPS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [fsa_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [fsa_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic signed [fsa_pkg::FRAME_W-1:0]     frame_time_us,
	input  wire fsa_pkg::fsa_cmd_t                      cmd,
	output fsa_pkg::fsa_sts_t                           sts,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic                                        out_step_granted,
	output logic [fsa_pkg::IDX_W-1:0]                   out_step_index,
	output logic [fsa_pkg::DROP_W-1:0]                  out_dropped_steps,
	output logic [fsa_pkg::FRAC_W-1:0]                  out_blend_fraction,
	output logic                                        out_last
);

	localparam int SW = $clog2(MAX_STEPS + 1);

	logic [fsa_pkg::PERIOD_W-1:0] cfg_period_q;
	logic [fsa_pkg::CATCH_W-1:0]  cfg_catch_q;
	logic [fsa_pkg::FRAME_W-1:0]  cfg_frame_q;
	logic [fsa_pkg::ACC_W-1:0]    acc_q;

	logic [fsa_pkg::PERIOD_W-1:0] rem_q;
	logic [fsa_pkg::ACC_W-1:0]    quo_q;
	logic [fsa_pkg::CNT_W-1:0]    cnt_q;
	logic [SW-1:0]                granted_q;
	logic [SW-1:0]                step_cnt_q;
	logic [fsa_pkg::DROP_W-1:0]   dropped_q;

	logic [fsa_pkg::PERIOD_W-1:0] period_eff;
	logic [SW-1:0]                catch_eff;
	logic [fsa_pkg::FRAME_W-1:0]  frame_max;
	logic [fsa_pkg::FRAME_W-1:0]  frame_clip;
	logic [fsa_pkg::ACC_W-1:0]    acc_sum;
	logic [fsa_pkg::PERIOD_W:0]   trial;
	logic                         trial_ge;
	logic [fsa_pkg::PERIOD_W:0]   trial_diff;
	logic [SW-1:0]                granted_d;

	// effective settings
	always_comb begin
		period_eff = cfg_period_q;
		if (cfg_period_q == '0) period_eff = fsa_pkg::DEF_PERIOD;
		else if (cfg_period_q < fsa_pkg::MIN_PERIOD) period_eff = fsa_pkg::MIN_PERIOD;
		else if (cfg_period_q > fsa_pkg::MAX_PERIOD) period_eff = fsa_pkg::MAX_PERIOD;

		if (32'(cfg_catch_q) > MAX_STEPS) catch_eff = SW'(MAX_STEPS);
		else if (cfg_catch_q == '0) catch_eff = SW'(1);
		else catch_eff = SW'(cfg_catch_q);

		frame_max = cfg_frame_q;
		if (cfg_frame_q == '0) frame_max = fsa_pkg::DEF_FRAME;
		if (frame_max < 24'(period_eff)) frame_max = 24'(period_eff);
	end

	// non-positive frame time adds nothing
	always_comb begin
		frame_clip = '0;
		if (!frame_time_us[fsa_pkg::FRAME_W-1]) frame_clip = frame_time_us;
		if (frame_clip > frame_max) frame_clip = frame_max;
		acc_sum = acc_q + 25'(frame_clip);
	end

	// one restoring divide step, shared by quotient and fraction
	always_comb begin
		trial      = {rem_q, quo_q[fsa_pkg::ACC_W-1]};
		trial_ge   = trial >= {1'b0, period_eff};
		trial_diff = trial - {1'b0, period_eff};
	end

	always_comb begin
		if (quo_q < 25'(catch_eff)) granted_d = SW'(quo_q);
		else granted_d = catch_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_period_q <= fsa_pkg::DEF_PERIOD;
			cfg_catch_q  <= fsa_pkg::DEF_CATCH;
			cfg_frame_q  <= fsa_pkg::DEF_FRAME;
			acc_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fsa_pkg::REG_STEP_PERIOD: begin
					cfg_period_q <= cfg_data[fsa_pkg::PERIOD_W-1:0];
					acc_q        <= '0;
				end
				fsa_pkg::REG_MAX_CATCH_UP: begin
					cfg_catch_q <= cfg_data[fsa_pkg::CATCH_W-1:0];
					acc_q       <= '0;
				end
				fsa_pkg::REG_MAX_FRAME: begin
					cfg_frame_q <= cfg_data;
					acc_q       <= '0;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end else if (cmd.split) begin
			acc_q <= 25'(rem_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			step_cnt_q <= '0;
			granted_q  <= '0;
		end else if (cmd.load) begin
			cnt_q <= fsa_pkg::DIV_LAST_CNT;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 5'd1;
		end else if (cmd.split) begin
			cnt_q      <= fsa_pkg::FRAC_LAST_CNT;
			step_cnt_q <= '0;
			granted_q  <= granted_d;
		end else if (cmd.emit_step) begin
			step_cnt_q <= step_cnt_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= acc_sum;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[fsa_pkg::PERIOD_W-1:0]
				: trial[fsa_pkg::PERIOD_W-1:0];
			quo_q <= {quo_q[fsa_pkg::ACC_W-2:0], trial_ge};
		end else if (cmd.split) begin
			dropped_q <= 24'(quo_q - 25'(granted_d));
			quo_q     <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_step || cmd.emit_final) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			out_step_granted   <= 1'b1;
			out_step_index     <= 3'(step_cnt_q);
			out_dropped_steps  <= '0;
			out_blend_fraction <= '0;
			out_last           <= 1'b0;
		end else if (cmd.emit_final) begin
			out_step_granted   <= 1'b0;
			out_step_index     <= '0;
			out_dropped_steps  <= dropped_q;
			out_blend_fraction <= quo_q[fsa_pkg::FRAC_W-1:0];
			out_last           <= 1'b1;
		end
	end

	assign sts.last_iter  = (cnt_q == '0);
	assign sts.more_steps = (step_cnt_q < granted_q);
	assign sts.out_free   = !out_valid || out_ready;

	// carried time stays below one period between frames
	a_acc_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < 25'(period_eff))
		else $error("accumulator not below the step period");

	a_final_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> !out_step_granted && (out_step_index == '0))
		else $error("summary result carries a step");

	a_grant_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> step_cnt_q < catch_eff)
		else $error("granted steps exceed catch-up limit");

endmodule

`default_nettype wire

@@ hw/rtl/fixed_step_accumulator.sv @@
// fixed_step_accumulator: top level, joins channels, config port, fsa_ctrl and fsa_dp
// depends on fsa_pkg, fsa_frame_if, fsa_step_if, fsa_ctrl, fsa_dp
// first result is registered from the emit state after divide, split and fraction
// results wait for a free output register; a new frame is taken only back in idle
// the shared one-bit-per-cycle divider computes 25 quotient bits, then 16 fraction bits
// reset: settings return to 16667 us, 5 steps, 250000 us and the accumulator clears
`default_nettype none

module fixed_step_accumulator #(
	parameter int MAX_STEPS = fsa_pkg::MAX_STEPS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [fsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fsa_pkg::CFG_DATA_W-1:0]  cfg_data,
	fsa_frame_if.sink                            frame_in,
	fsa_step_if.source                           step_out
);

	fsa_pkg::fsa_cmd_t cmd;
	fsa_pkg::fsa_sts_t sts;

	fsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame_in.valid),
		.in_ready (frame_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fsa_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.frame_time_us      (frame_in.frame_time_us),
		.cmd                (cmd),
		.sts                (sts),
		.out_ready          (step_out.ready),
		.out_valid          (step_out.valid),
		.out_step_granted   (step_out.step_granted),
		.out_step_index     (step_out.step_index),
		.out_dropped_steps  (step_out.dropped_steps),
		.out_blend_fraction (step_out.blend_fraction),
		.out_last           (step_out.last)
	);

endmodule

`default_nettype wire
